FILE: rtl/core/asa_pkg.sv
`timescale 1ns / 1ps

package asa_pkg;

  localparam int CH_W       = 5;
  localparam int CNT_W      = 5;
  localparam int SUM_W      = 16;
  localparam int MASK_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;

  typedef enum logic [1:0] {
    REG_FIRST_CHANNEL,
    REG_LAST_CHANNEL,
    REG_COLLECT_MASK,
    REG_SAMPLES_PER_AVG
  } reg_index_t;

  localparam logic [CH_W-1:0]   FIRST_CHANNEL_RST = 5'd0;
  localparam logic [CH_W-1:0]   LAST_CHANNEL_RST  = 5'd31;
  localparam logic [MASK_W-1:0] COLLECT_MASK_RST  = '1;
  localparam logic [CNT_W-1:0]  SAMPLES_AVG_RST   = 5'd4;

  typedef struct packed {
    logic [CH_W-1:0]   first_channel;
    logic [CH_W-1:0]   last_channel;
    logic [MASK_W-1:0] collect_mask;
    logic [CNT_W-1:0]  samples_per_average;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]  next_channel;
    logic             sum_ready;
    logic [CH_W-1:0]  sum_channel;
    logic [SUM_W-1:0] sum_value;
    logic             scan_done;
  } result_t;

endpackage

FILE: rtl/core/adc_scan_averager.sv
`timescale 1ns / 1ps
// ADC scan averager.
// Slave stream (s_*) takes one conversion result per beat for the channel
// currently selected. Each input beat yields exactly one master beat (m_*)
// that reports the channel to convert next and, when the beat completed the
// configured number of samples, the channel's sum and whether the scan wrapped.
// An input beat passes through the input register, then through the accumulate
// and channel search into the output register. Throughput is one beat per
// cycle while m_tready is not held low; the path that sets it is the
// priority search over the collect mask feeding the channel register.
// The APB port sets first/last channel, the collect mask and the number of
// samples per average; write it only while no beats are in flight.
// Reset clears the valid bits of both pipeline registers, the sum and sample
// count, returns the registers to their defaults and selects channel 0.
// A stalled output (m_tready low) holds its beat; the input register keeps
// accepting until it is full, so one more beat is taken while a result waits.
module adc_scan_averager #(
  parameter int CHANNEL_COUNT = 32,
  parameter int SAMPLE_BITS   = 12,
  parameter int MAX_AVERAGE   = 16,
  localparam int IN_DATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [IN_DATA_W-1:0]              s_tdata,   // sample
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // next_channel[4:0], sum_channel[9:5], sum_value[25:10], zero fill
  output logic [asa_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [asa_pkg::OUT_USER_W-1:0]    m_tuser,   // sum_ready[0], scan_done[1]
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [asa_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [asa_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [asa_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import asa_pkg::*;

  localparam int PAD_W = OUT_DATA_W - (2 * CH_W + SUM_W);

  cfg_t                   cfg;
  result_t                res;
  result_t                out_res;
  logic                   in_valid;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   advance;
  logic                   s_accept;

  asa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  asa_core #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .MAX_AVERAGE   (MAX_AVERAGE)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .sample (in_sample),
    .cfg    (cfg),
    .res    (res)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      in_valid <= s_accept || (in_valid && !advance);
      m_tvalid <= advance || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_sample <= s_tdata[SAMPLE_BITS-1:0];
    end
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_res.sum_value, out_res.sum_channel,
                    out_res.next_channel};
  assign m_tuser = {out_res.scan_done, out_res.sum_ready};

endmodule

FILE: rtl/core/asa_regs.sv
`timescale 1ns / 1ps

module asa_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [asa_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [asa_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [asa_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output asa_pkg::cfg_t                     cfg
);
  import asa_pkg::*;

  reg_index_t reg_sel;
  logic       wr_en;

  assign reg_sel = reg_index_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_channel       <= FIRST_CHANNEL_RST;
      cfg.last_channel        <= LAST_CHANNEL_RST;
      cfg.collect_mask        <= COLLECT_MASK_RST;
      cfg.samples_per_average <= SAMPLES_AVG_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_FIRST_CHANNEL:   cfg.first_channel       <= pwdata[CH_W-1:0];
        REG_LAST_CHANNEL:    cfg.last_channel        <= pwdata[CH_W-1:0];
        REG_COLLECT_MASK:    cfg.collect_mask        <= pwdata[MASK_W-1:0];
        REG_SAMPLES_PER_AVG: cfg.samples_per_average <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_FIRST_CHANNEL:   prdata = CFG_DATA_W'(cfg.first_channel);
      REG_LAST_CHANNEL:    prdata = CFG_DATA_W'(cfg.last_channel);
      REG_COLLECT_MASK:    prdata = CFG_DATA_W'(cfg.collect_mask);
      REG_SAMPLES_PER_AVG: prdata = CFG_DATA_W'(cfg.samples_per_average);
      default:             prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/asa_sel.sv
`timescale 1ns / 1ps

module asa_sel #(
  parameter int CHANNEL_COUNT = 32
) (
  input  logic [asa_pkg::MASK_W-1:0] collect_mask,
  input  logic [asa_pkg::CH_W-1:0]   last_channel,
  input  logic [asa_pkg::CH_W-1:0]   cur_channel,
  output logic                       found,
  output logic [asa_pkg::CH_W-1:0]   found_channel
);
  import asa_pkg::*;

  localparam logic [CH_W-1:0] TOP_CHANNEL = CH_W'(CHANNEL_COUNT - 1);

  logic [CH_W-1:0] limit;

  assign limit = (last_channel > TOP_CHANNEL) ? TOP_CHANNEL : last_channel;

  // lowest collected channel above the current one, up to the limit
  always_comb begin
    found         = 1'b0;
    found_channel = '0;
    for (int c = MASK_W - 1; c >= 0; c--) begin
      if (collect_mask[c] && (CH_W'(c) > cur_channel) && (CH_W'(c) <= limit)) begin
        found         = 1'b1;
        found_channel = CH_W'(c);
      end
    end
  end

endmodule

FILE: rtl/core/asa_core.sv
`timescale 1ns / 1ps

module asa_core #(
  parameter int CHANNEL_COUNT = 32,
  parameter int SAMPLE_BITS   = 12,
  parameter int MAX_AVERAGE   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  asa_pkg::cfg_t          cfg,
  output asa_pkg::result_t       res
);
  import asa_pkg::*;

  localparam logic [CNT_W-1:0] MAX_AVG = CNT_W'(MAX_AVERAGE);

  logic [CH_W-1:0]  current_channel, current_channel_next;
  logic [CNT_W-1:0] samples_taken, samples_taken_next;
  logic [SUM_W-1:0] running_sum, running_sum_next;

  logic [CNT_W-1:0] threshold;
  logic [CNT_W-1:0] taken_inc;
  logic [SUM_W-1:0] sum_add;
  logic             found;
  logic [CH_W-1:0]  found_channel;

  asa_sel #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_sel (
    .collect_mask  (cfg.collect_mask),
    .last_channel  (cfg.last_channel),
    .cur_channel   (current_channel),
    .found         (found),
    .found_channel (found_channel)
  );

  always_comb begin
    if (cfg.samples_per_average == '0) begin
      threshold = CNT_W'(1);
    end else if (cfg.samples_per_average > MAX_AVG) begin
      threshold = MAX_AVG;
    end else begin
      threshold = cfg.samples_per_average;
    end
  end

  assign taken_inc = samples_taken + CNT_W'(1);
  assign sum_add   = running_sum + SUM_W'(sample);

  always_comb begin
    current_channel_next = current_channel;
    samples_taken_next   = taken_inc;
    running_sum_next     = sum_add;
    res                  = '0;
    if (taken_inc >= threshold) begin
      samples_taken_next = '0;
      running_sum_next   = '0;
      res.sum_ready      = 1'b1;
      res.sum_channel    = current_channel;
      res.sum_value      = sum_add;
      if (found) begin
        current_channel_next = found_channel;
      end else begin
        // nothing left in this scan: wrap and flag
        current_channel_next = cfg.first_channel;
        res.scan_done        = 1'b1;
      end
    end
    res.next_channel = current_channel_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_channel <= FIRST_CHANNEL_RST;
      samples_taken   <= '0;
      running_sum     <= '0;
    end else if (step) begin
      current_channel <= current_channel_next;
      samples_taken   <= samples_taken_next;
      running_sum     <= running_sum_next;
    end
  end

endmodule

FILE: rtl/core/asa_checker.sv
`timescale 1ns / 1ps

module asa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [asa_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [asa_pkg::OUT_USER_W-1:0] m_tuser
);

  // without a completed sum the sum fields and the wrap flag stay zero
  a_idle_fields_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata[25:5] == '0) && !m_tuser[1])
    else $error("sum fields set without sum_ready");

  // a completed sum that does not wrap moves to a higher channel
  a_moves_up : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] && !m_tuser[1] |-> m_tdata[4:0] > m_tdata[9:5])
    else $error("next channel not above emitted channel");

  // no beat is offered in the first cycle out of reset
  a_reset_empty : assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  a_hold_stall : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output beat changed");

endmodule

bind adc_scan_averager asa_checker u_asa_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
